/* rtl/dta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_pkg
// Types, constants and calendar helpers shared by the date-time adder.
// ----------------------------------------------------------------------------
package dta_pkg;

   // shared divider by a constant: pre-shift, reciprocal multiply, remainder
   localparam int DIV_BITS  = 32;
   localparam int OP_BITS   = 30;   // dividend after the power-of-two pre-shift
   localparam int MAG_BITS  = 31;
   localparam int REM_BITS  = 9;
   localparam int DAYS_BITS = 15;   // carried days stay below 2^15
   localparam int FIFO_DEPTH = 2;   // power of two

   localparam logic [REM_BITS-1:0] DIVISOR_MINUTE = 9'd60;
   localparam logic [REM_BITS-1:0] DIVISOR_DAY    = 9'd24;
   localparam logic [REM_BITS-1:0] DIVISOR_CYCLE  = 9'd400;

   // x / 60  = ((x >> 2) * ceil(2^34 / 15)) >> 34
   // x / 24  = ((x >> 3) * ceil(2^31 / 3))  >> 31
   // x / 400 = ((x >> 4) * ceil(2^33 / 25)) >> 33
   // exact for every 32-bit x
   localparam logic [MAG_BITS-1:0] MAGIC_MINUTE = 31'd1145324613;
   localparam logic [MAG_BITS-1:0] MAGIC_DAY    = 31'd715827883;
   localparam logic [MAG_BITS-1:0] MAGIC_CYCLE  = 31'd343597384;

   localparam logic [REM_BITS-1:0] CYCLE_LAST   = 9'd399;
   localparam logic [REM_BITS-1:0] CYCLE_CENT_1 = 9'd100;
   localparam logic [REM_BITS-1:0] CYCLE_CENT_2 = 9'd200;
   localparam logic [REM_BITS-1:0] CYCLE_CENT_3 = 9'd300;

   localparam logic [3:0] MONTH_DEC  = 4'd12;
   localparam logic [3:0] MONTH_WRAP = 4'd11;
   localparam logic [2:0] WEEKDAY_LAST = 3'd6;

   typedef struct packed {
      logic [15:0] start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [4:0]  start_hour;
      logic [5:0]  start_minute;
      logic [5:0]  start_second;
      logic [2:0]  start_weekday;
      logic [30:0] seconds_to_add;
   } req_word_type;

   typedef struct packed {
      logic [15:0] new_year;
      logic [3:0]  new_month;
      logic [4:0]  new_day;
      logic [4:0]  new_hour;
      logic [5:0]  new_minute;
      logic [5:0]  new_second;
      logic [2:0]  new_weekday;
      logic        year_overflow;
   } rsp_word_type;

   // time of day resolved, day count still to walk
   typedef struct packed {
      logic [15:0]          year;
      logic [REM_BITS-1:0]  year_r400;
      logic [3:0]           month;
      logic [4:0]           day;
      logic [4:0]           hour;
      logic [5:0]           minute;
      logic [5:0]           second;
      logic [2:0]           weekday;
      logic [DAYS_BITS-1:0] days;
   } job_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [REM_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
      logic [REM_BITS-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_SEC,
      FR_MIN,
      FR_HOUR,
      FR_YEAR,
      FR_PUSH
   } front_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_WALK
   } back_state_type;

   // leap test from year mod 400
   function automatic logic is_leap(input logic [REM_BITS-1:0] r400);
      logic cent;
      cent = (r400 == CYCLE_CENT_1) || (r400 == CYCLE_CENT_2) || (r400 == CYCLE_CENT_3);
      return ((r400[1:0] == 2'd0) && !cent) || (r400 == '0);
   endfunction

   // invalid month codes are zero days long
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

/* rtl/dta_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_div
// Divider by 60, 24 or 400: pre-shift and reciprocal multiply, then the
// remainder; done pulses with the registered remainder.
// ----------------------------------------------------------------------------
module dta_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dta_pkg::div_req_type div_req,
   output dta_pkg::div_rsp_type      div_rsp
);

   localparam int PROD_BITS = dta_pkg::OP_BITS + dta_pkg::MAG_BITS;

   logic                            mul_ff, mul_in;   // operands loaded
   logic                            fix_ff, fix_in;   // quotient ready
   logic                            done_ff, done_in;
   logic [dta_pkg::OP_BITS-1:0]     op_ff, op_in;
   logic [dta_pkg::MAG_BITS-1:0]    mag_ff, mag_in;
   logic [dta_pkg::REM_BITS-1:0]    dvd_lo_ff, dvd_lo_in;
   logic [dta_pkg::REM_BITS-1:0]    dsr_ff, dsr_in;
   logic [dta_pkg::DIV_BITS-1:0]    quo_ff, quo_in;
   logic [dta_pkg::REM_BITS-1:0]    rem_ff, rem_in;

   logic [PROD_BITS-1:0]            prod;
   logic [2*dta_pkg::REM_BITS-1:0]  back_mul;

   assign prod     = op_ff * mag_ff;
   assign back_mul = quo_ff[dta_pkg::REM_BITS-1:0] * dsr_ff;

   always_comb begin
      mul_in    = div_req.start;
      fix_in    = mul_ff;
      done_in   = fix_ff;
      op_in     = op_ff;
      mag_in    = mag_ff;
      dvd_lo_in = dvd_lo_ff;
      dsr_in    = dsr_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (div_req.start) begin
         // strip the power-of-two factor of the divisor first
         dvd_lo_in = div_req.dividend[dta_pkg::REM_BITS-1:0];
         dsr_in    = div_req.divisor;
         case (div_req.divisor)
            dta_pkg::DIVISOR_DAY: begin
               op_in  = dta_pkg::OP_BITS'(div_req.dividend >> 3);
               mag_in = dta_pkg::MAGIC_DAY;
            end
            dta_pkg::DIVISOR_CYCLE: begin
               op_in  = dta_pkg::OP_BITS'(div_req.dividend >> 4);
               mag_in = dta_pkg::MAGIC_CYCLE;
            end
            default: begin
               op_in  = dta_pkg::OP_BITS'(div_req.dividend >> 2);
               mag_in = dta_pkg::MAGIC_MINUTE;
            end
         endcase
      end
      if (mul_ff) begin
         case (dsr_ff)
            dta_pkg::DIVISOR_DAY:   quo_in = dta_pkg::DIV_BITS'(prod >> 31);
            dta_pkg::DIVISOR_CYCLE: quo_in = dta_pkg::DIV_BITS'(prod >> 33);
            default:                quo_in = dta_pkg::DIV_BITS'(prod >> 34);
         endcase
      end
      if (fix_ff) begin
         // remainder is below 512, so the low nine bits of the difference do
         rem_in = dvd_lo_ff - back_mul[dta_pkg::REM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      mag_ff    <= mag_in;
      dvd_lo_ff <= dvd_lo_in;
      dsr_ff    <= dsr_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

/* rtl/dta_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_front
// Takes a request word, resolves seconds/minutes/hours and the carried day
// count, finds year mod 400, and queues a job for the day walker.
// ----------------------------------------------------------------------------
module dta_front #(
   parameter int YEAR_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dta_pkg::req_word_type req_word,
   output dta_pkg::div_req_type       div_req,
   input  wire dta_pkg::div_rsp_type  div_rsp,
   output logic                       push,
   output dta_pkg::job_type           push_job,
   input  wire logic                  fifo_full
);

   localparam logic [15:0] YEAR_MASK16 = (YEAR_BITS >= 16) ? 16'hFFFF :
      16'((32'd1 << YEAR_BITS) - 32'd1);

   dta_pkg::front_state_type state_ff, state_in;

   dta_pkg::req_word_type           item_ff, item_in;
   logic [5:0]                      sec_ff, sec_in;
   logic [5:0]                      min_ff, min_in;
   logic [4:0]                      hour_ff, hour_in;
   logic [dta_pkg::DAYS_BITS-1:0]   days_ff, days_in;
   logic [dta_pkg::REM_BITS-1:0]    r400_ff, r400_in;
   logic [15:0]                     year_red;

   assign year_red = item_ff.start_year & YEAR_MASK16;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dta_pkg::FR_IDLE: if (req_valid)    state_in = dta_pkg::FR_SEC;
         dta_pkg::FR_SEC:  if (div_rsp.done) state_in = dta_pkg::FR_MIN;
         dta_pkg::FR_MIN:  if (div_rsp.done) state_in = dta_pkg::FR_HOUR;
         dta_pkg::FR_HOUR: if (div_rsp.done) state_in = dta_pkg::FR_YEAR;
         dta_pkg::FR_YEAR: if (div_rsp.done) state_in = dta_pkg::FR_PUSH;
         dta_pkg::FR_PUSH: if (!fifo_full)   state_in = dta_pkg::FR_IDLE;
         default:                            state_in = dta_pkg::FR_IDLE;
      endcase
   end

   // outputs: each divide result but the last launches the next divide
   always_comb begin
      req_ready        = 1'b0;
      push             = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = dta_pkg::DIVISOR_MINUTE;
      case (state_ff)
         dta_pkg::FR_IDLE: begin
            req_ready        = 1'b1;
            div_req.start    = req_valid;
            div_req.dividend = dta_pkg::DIV_BITS'(req_word.start_second) +
                               dta_pkg::DIV_BITS'(req_word.seconds_to_add);
         end
         dta_pkg::FR_SEC: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = dta_pkg::DIV_BITS'(item_ff.start_minute) + div_rsp.quotient;
         end
         dta_pkg::FR_MIN: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = dta_pkg::DIV_BITS'(item_ff.start_hour) + div_rsp.quotient;
            div_req.divisor  = dta_pkg::DIVISOR_DAY;
         end
         dta_pkg::FR_HOUR: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = dta_pkg::DIV_BITS'(year_red);
            div_req.divisor  = dta_pkg::DIVISOR_CYCLE;
         end
         dta_pkg::FR_YEAR: begin
         end
         dta_pkg::FR_PUSH: begin
            push = !fifo_full;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      item_in = item_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      days_in = days_ff;
      r400_in = r400_ff;
      if ((state_ff == dta_pkg::FR_IDLE) && req_valid) item_in = req_word;
      if (div_rsp.done) begin
         if (state_ff == dta_pkg::FR_SEC) sec_in = div_rsp.remainder[5:0];
         if (state_ff == dta_pkg::FR_MIN) min_in = div_rsp.remainder[5:0];
         if (state_ff == dta_pkg::FR_HOUR) begin
            hour_in = div_rsp.remainder[4:0];
            days_in = div_rsp.quotient[dta_pkg::DAYS_BITS-1:0];
         end
         if (state_ff == dta_pkg::FR_YEAR) r400_in = div_rsp.remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dta_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sec_ff  <= sec_in;
      min_ff  <= min_in;
      hour_ff <= hour_in;
      days_ff <= days_in;
      r400_ff <= r400_in;
   end

   always_comb begin
      push_job.year      = year_red;
      push_job.year_r400 = r400_ff;
      push_job.month     = item_ff.start_month;
      push_job.day       = item_ff.start_day;
      push_job.hour      = hour_ff;
      push_job.minute    = min_ff;
      push_job.second    = sec_ff;
      push_job.weekday   = item_ff.start_weekday;
      push_job.days      = days_ff;
   end

endmodule
`default_nettype wire

/* rtl/dta_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_fifo
// Short job queue between the front end and the day walker.
// ----------------------------------------------------------------------------
module dta_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dta_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output dta_pkg::job_type      pop_job,
   output logic                  not_empty
);

   localparam int PTR_BITS = $clog2(dta_pkg::FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(dta_pkg::FIFO_DEPTH + 1);

   dta_pkg::job_type     entry_ff [dta_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign full      = count_ff == CNT_BITS'(dta_pkg::FIFO_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

/* rtl/dta_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_back
// Day walker: steps the date one day per cycle, then loads the output word.
// ----------------------------------------------------------------------------
module dta_back #(
   parameter int YEAR_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire dta_pkg::job_type job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dta_pkg::rsp_word_type rsp_word
);

   dta_pkg::back_state_type state_ff, state_in;

   logic [YEAR_BITS-1:0]          year_ff, year_in;
   logic [dta_pkg::REM_BITS-1:0]  r400_ff, r400_in;
   logic [3:0]                    month_ff, month_in;
   logic [4:0]                    day_ff, day_in;
   logic [2:0]                    wday_ff, wday_in;
   logic [dta_pkg::DAYS_BITS-1:0] days_ff, days_in;
   logic                          ovf_ff, ovf_in;
   logic [4:0]                    hour_ff, hour_in;
   logic [5:0]                    min_ff, min_in;
   logic [5:0]                    sec_ff, sec_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   dta_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic       step;
   logic       emit;
   logic [4:0] len;
   logic [5:0] day_inc;
   logic       past_end;
   logic       year_last;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dta_pkg::BK_IDLE: if (job_valid) state_in = dta_pkg::BK_WALK;
         dta_pkg::BK_WALK: if (emit)      state_in = dta_pkg::BK_IDLE;
         default:                         state_in = dta_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop  = 1'b0;
      step = 1'b0;
      emit = 1'b0;
      case (state_ff)
         dta_pkg::BK_IDLE: pop = job_valid;
         dta_pkg::BK_WALK: begin
            step = days_ff != '0;
            emit = (days_ff == '0) && (!rsp_valid_ff || rsp_ready);
         end
         default: begin
         end
      endcase
   end

   assign len       = dta_pkg::month_len(month_ff, dta_pkg::is_leap(r400_ff));
   assign day_inc   = {1'b0, day_ff} + 6'd1;
   assign past_end  = day_inc > {1'b0, len};
   assign year_last = year_ff == {YEAR_BITS{1'b1}};

   always_comb begin
      year_in  = year_ff;
      r400_in  = r400_ff;
      month_in = month_ff;
      day_in   = day_ff;
      wday_in  = wday_ff;
      days_in  = days_ff;
      ovf_in   = ovf_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      if (pop) begin
         year_in  = YEAR_BITS'(job.year);
         r400_in  = job.year_r400;
         month_in = job.month;
         day_in   = job.day;
         // weekday seven counts as weekday zero
         wday_in  = (job.weekday > dta_pkg::WEEKDAY_LAST) ? 3'd0 : job.weekday;
         days_in  = job.days;
         ovf_in   = 1'b0;
         hour_in  = job.hour;
         min_in   = job.minute;
         sec_in   = job.second;
      end else if (step) begin
         days_in = days_ff - 1'b1;
         wday_in = (wday_ff == dta_pkg::WEEKDAY_LAST) ? 3'd0 : wday_ff + 3'd1;
         if (past_end) begin
            day_in = 5'd1;
            if (month_ff >= dta_pkg::MONTH_DEC) begin
               // December and invalid high codes carry into the next year
               month_in = month_ff - dta_pkg::MONTH_WRAP;
               if (year_last) begin
                  year_in = '0;
                  r400_in = '0;
                  ovf_in  = 1'b1;
               end else begin
                  year_in = year_ff + 1'b1;
                  r400_in = (r400_ff == dta_pkg::CYCLE_LAST) ? '0 : r400_ff + 1'b1;
               end
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            day_in = day_inc[4:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = emit | (rsp_valid_ff & !rsp_ready);
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         rsp_word_in.new_year      = 16'(year_ff);
         rsp_word_in.new_month     = month_ff;
         rsp_word_in.new_day       = day_ff;
         rsp_word_in.new_hour      = hour_ff;
         rsp_word_in.new_minute    = min_ff;
         rsp_word_in.new_second    = sec_ff;
         rsp_word_in.new_weekday   = wday_ff;
         rsp_word_in.year_overflow = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dta_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff     <= year_in;
      r400_ff     <= r400_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      wday_ff     <= wday_in;
      days_ff     <= days_in;
      ovf_ff      <= ovf_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      sec_ff      <= sec_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

/* rtl/date_time_add_seconds.sv */
`timescale 1ns / 1ps
`default_nettype none
// Front end: four passes of one shared constant divider (sec, min, hour,
//   year mod 400) plus capture and push; it takes no new word until its job is pushed.
// Back end: one day per cycle in the day walker; it pops the next job once a word is emitted.
// A 2-entry queue decouples the front end and the back end.
// Reset: synchronous, active high; clears all control state, no pending words.
// ----------------------------------------------------------------------------
// date_time_add_seconds
// Adds a second count to a Gregorian date-time, with weekday and year wrap.
// ----------------------------------------------------------------------------
module date_time_add_seconds #(
   parameter int YEAR_BITS = 16      // year storage width, 12 to 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dta_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dta_pkg::rsp_word_type      rsp_word
);

   dta_pkg::div_req_type div_req;
   dta_pkg::div_rsp_type div_rsp;
   dta_pkg::job_type     push_job;
   dta_pkg::job_type     pop_job;
   logic                 push;
   logic                 pop;
   logic                 fifo_full;
   logic                 job_valid;

   // Front end: request capture, then sec/min/hour carries by division by 60,
   // 60 and 24 and the leap-cycle position (year mod 400), all on one divider.
   dta_front #(
      .YEAR_BITS (YEAR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .push      (push),
      .push_job  (push_job),
      .fifo_full (fifo_full)
   );

   // Shared divider by a constant: reciprocal multiply, then the remainder.
   dta_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Job queue: lets the front resolve the next word while days are walked.
   dta_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (fifo_full),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (job_valid)
   );

   // Day walker with the response register; a finished word waits there while
   // the walker already takes the next job.
   dta_back #(
      .YEAR_BITS (YEAR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

/* rtl/dta_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_checker
// Port-level checks of the date-time adder, bound to the top level.
// ----------------------------------------------------------------------------
module dta_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire dta_pkg::rsp_word_type rsp_word
);

   logic [3:0] pend_ff, pend_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) pend_in = pend_ff + 4'd1;
      if (rsp_fire && !req_fire) pend_in = pend_ff - 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("response without a pending request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 4'd5)
      else $error("more words in flight than the design holds");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.new_hour < 5'd24) && (rsp_word.new_minute < 6'd60) &&
                    (rsp_word.new_second < 6'd60) && (rsp_word.new_weekday < 3'd7))
      else $error("time of day or weekday out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response changed");

endmodule

bind date_time_add_seconds dta_checker u_dta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
`default_nettype wire
